### design/pwl_pkg.sv
package pwl_pkg;

   // fixed field widths
   localparam int VALUE_BITS  = 16;
   localparam int INDEX_BITS  = 4;
   localparam int COUNT_BITS  = 5;
   localparam int STATUS_BITS = 2;

   // stream packing
   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(2);

   // item kind carried on req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_INSIDE = 2'd0,
      STATUS_BELOW  = 2'd1,
      STATUS_ABOVE  = 2'd2
   } range_status_type;

   // table read address select
   typedef enum logic [1:0] {
      RD_ZERO = 2'd0,
      RD_ONE  = 2'd1,
      RD_LAST = 2'd2,
      RD_NEXT = 2'd3
   } rd_sel_type;

   // source of the result value
   typedef enum logic [1:0] {
      RES_DATA_Y = 2'd0,
      RES_LAST_Y = 2'd1,
      RES_LERP   = 2'd2
   } res_kind_type;

   typedef struct packed {
      logic             write_point;
      logic             load_query;
      logic             cap_prev;
      logic             cap_last;
      logic             scan_init;
      logic             scan_step;
      logic             cap_seg;
      logic             mul;
      logic             div_step;
      logic             res_load;
      res_kind_type     res_kind;
      range_status_type res_status;
      logic             out_load;
      rd_sel_type       rd_sel;
   } cmd_type;

   typedef struct packed {
      logic below;
      logic above;
      logic hit;
      logic scan_end;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

### design/pwl_ctrl.sv
module pwl_ctrl import pwl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     req_op,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_FIRST  = 9'b000000010,
      ST_LOW    = 9'b000000100,
      ST_HIGH   = 9'b000001000,
      ST_SCAN   = 9'b000010000,
      ST_MUL    = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_FINISH = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_op == OP_QUERY) begin
                  cmd.load_query = 1'b1;
                  state_in       = ST_FIRST;
               end else begin
                  cmd.write_point = 1'b1;
               end
            end
         end
         ST_FIRST: begin
            cmd.rd_sel = RD_ZERO;
            state_in   = ST_LOW;
         end
         // entry 0 on the read port: clamp below?
         ST_LOW: begin
            cmd.cap_prev = 1'b1;
            cmd.rd_sel   = RD_LAST;
            if (stat.below) begin
               cmd.res_load   = 1'b1;
               cmd.res_kind   = RES_DATA_Y;
               cmd.res_status = STATUS_BELOW;
               state_in       = ST_OUT;
            end else begin
               state_in = ST_HIGH;
            end
         end
         // last entry in use on the read port: clamp above?
         ST_HIGH: begin
            cmd.cap_last  = 1'b1;
            cmd.scan_init = 1'b1;
            cmd.rd_sel    = RD_ONE;
            if (stat.above) begin
               cmd.res_load   = 1'b1;
               cmd.res_kind   = RES_DATA_Y;
               cmd.res_status = STATUS_ABOVE;
               state_in       = ST_OUT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         // one segment per cycle
         ST_SCAN: begin
            cmd.rd_sel = RD_NEXT;
            if (stat.hit) begin
               cmd.cap_seg = 1'b1;
               state_in    = ST_MUL;
            end else if (stat.scan_end) begin
               cmd.res_load   = 1'b1;
               cmd.res_kind   = RES_LAST_Y;
               cmd.res_status = STATUS_INSIDE;
               state_in       = ST_OUT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.res_load   = 1'b1;
            cmd.res_kind   = RES_LERP;
            cmd.res_status = STATUS_INSIDE;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/pwl_dpath.sv
module pwl_dpath import pwl_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [COUNT_BITS-1:0]  csr_wr_data,
   // request fields
   input  logic [INDEX_BITS-1:0]  point_index,
   input  logic [VALUE_BITS-1:0]  point_x,
   input  logic [VALUE_BITS-1:0]  point_y,
   input  logic [VALUE_BITS-1:0]  query_x,
   // control
   input  cmd_type                cmd,
   output stat_type               stat,
   // result
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [VALUE_BITS-1:0]  interp_value,
   output logic [STATUS_BITS-1:0] range_status
);

   localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW     = $clog2(MAX_POINTS + 1);
   localparam int CW     = (NW > COUNT_BITS) ? NW : COUNT_BITS;
   localparam int DCW    = $clog2(VALUE_BITS + 1);
   localparam int PROD_W = 2 * VALUE_BITS;

   // breakpoint table, y in the upper half
   logic [PROD_W-1:0]     mem [MAX_POINTS];
   logic [PROD_W-1:0]     rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic [VALUE_BITS-1:0] data_x, data_y;

   logic [COUNT_BITS-1:0] count_ff;
   logic [CW-1:0]         count_ext, used_n;
   logic [AW-1:0]         last_idx;
   logic                  wr_ok;

   logic [VALUE_BITS-1:0] q_ff, prev_x_ff, prev_y_ff, seg_x_ff, seg_y_ff, last_y_ff;
   logic [AW-1:0]         scan_ff;

   logic [VALUE_BITS-1:0] off, dy;
   logic [PROD_W-1:0]     prod;
   logic [VALUE_BITS-1:0] dx_ff, rem_ff, low_ff;
   logic                  neg_ff;
   logic [DCW-1:0]        div_cnt_ff;
   logic [VALUE_BITS:0]   trial;
   logic                  trial_ge;

   logic [VALUE_BITS-1:0] lerp_value, res_value_ff, res_pick;
   range_status_type      res_status_ff;

   logic                   out_valid_ff;
   logic [VALUE_BITS-1:0]  out_value_ff;
   logic [STATUS_BITS-1:0] out_status_ff;

   assign data_x = rd_data_ff[VALUE_BITS-1:0];
   assign data_y = rd_data_ff[PROD_W-1:VALUE_BITS];

   // point count clamped to 2..MAX_POINTS
   assign count_ext = CW'(count_ff);
   always_comb begin
      if (count_ext < CW'(2)) begin
         used_n = CW'(2);
      end else if (count_ext > CW'(MAX_POINTS)) begin
         used_n = CW'(MAX_POINTS);
      end else begin
         used_n = count_ext;
      end
   end
   assign last_idx = AW'(used_n - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // read address
   always_comb begin
      case (cmd.rd_sel)
         RD_ZERO: rd_addr = '0;
         RD_ONE:  rd_addr = AW'(1);
         RD_LAST: rd_addr = last_idx;
         RD_NEXT: rd_addr = scan_ff + AW'(1);
         default: rd_addr = '0;
      endcase
   end

   // table: one write port, one registered read port
   assign wr_ok = (32'(point_index) < 32'(MAX_POINTS));
   always_ff @(posedge clock) begin
      if (cmd.write_point && wr_ok) begin
         mem[AW'(point_index)] <= {point_y, point_x};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // query and segment registers
   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         q_ff <= query_x;
      end
      if (cmd.cap_prev || cmd.scan_step) begin
         prev_x_ff <= data_x;
         prev_y_ff <= data_y;
      end
      if (cmd.cap_last) begin
         last_y_ff <= data_y;
      end
      if (cmd.scan_init) begin
         scan_ff <= AW'(1);
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + AW'(1);
      end
      if (cmd.cap_seg) begin
         seg_x_ff <= data_x;
         seg_y_ff <= data_y;
      end
   end

   // offset times rise magnitude
   assign off  = q_ff - prev_x_ff;
   assign dy   = (seg_y_ff < prev_y_ff) ? (prev_y_ff - seg_y_ff) : (seg_y_ff - prev_y_ff);
   assign prod = PROD_W'(off) * PROD_W'(dy);

   // restoring divider, one quotient bit per cycle; upper half of the
   // product is below dx since the quotient never exceeds the rise
   assign trial    = {rem_ff, low_ff[VALUE_BITS-1]};
   assign trial_ge = (trial >= {1'b0, dx_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         dx_ff      <= seg_x_ff - prev_x_ff;
         neg_ff     <= (seg_y_ff < prev_y_ff);
         rem_ff     <= prod[PROD_W-1:VALUE_BITS];
         low_ff     <= prod[VALUE_BITS-1:0];
         div_cnt_ff <= DCW'(VALUE_BITS);
      end else if (cmd.div_step) begin
         rem_ff     <= trial_ge ? VALUE_BITS'(trial - {1'b0, dx_ff})
                                : trial[VALUE_BITS-1:0];
         low_ff     <= {low_ff[VALUE_BITS-2:0], trial_ge};
         div_cnt_ff <= div_cnt_ff - DCW'(1);
      end
   end

   // final value; zero-width segment gives y[i]
   always_comb begin
      if (dx_ff == '0) begin
         lerp_value = prev_y_ff;
      end else if (neg_ff) begin
         lerp_value = prev_y_ff - low_ff;
      end else begin
         lerp_value = prev_y_ff + low_ff;
      end
   end

   always_comb begin
      case (cmd.res_kind)
         RES_DATA_Y: res_pick = data_y;
         RES_LAST_Y: res_pick = last_y_ff;
         RES_LERP:   res_pick = lerp_value;
         default:    res_pick = data_y;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_value_ff  <= res_pick;
         res_status_ff <= cmd.res_status;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_value_ff  <= res_value_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign interp_value = out_value_ff;
   assign range_status = out_status_ff;

   // status to the controller
   assign stat.below    = (q_ff < data_x);
   assign stat.above    = (q_ff > data_x);
   assign stat.hit      = (q_ff >= prev_x_ff) && (q_ff <= data_x);
   assign stat.scan_end = (scan_ff == last_idx);
   assign stat.div_last = (div_cnt_ff == DCW'(1));
   assign stat.out_free = !out_valid_ff || rsp_tready;

endmodule

### design/piecewise_linear_lookup.sv
// Channel   Dir  Handshake          Payload
// req       in   tvalid/tready      tuser: op; tdata: index, x, y, query
// rsp       out  tvalid/tready      tuser: range_status; tdata: interp_value
// csr       in   wr_en              wr_data: point_count
//
// A breakpoint write is taken in the idle state, and the block stays idle. A query is
// clamped below by entry 0 or above by the last entry in use; else the table is read
// one entry per cycle to find its segment, and the divider gives one bit per cycle. When
// no segment holds it, the last entry's y is given. The block then returns to idle.
// Reset clears the control state and sets point_count to 2; the table holds nothing
// until written. A stalled rsp holds its item; the next item is still taken meanwhile.
module piecewise_linear_lookup import pwl_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_tuser,   // [0] op
   // [3:0] point_index, [19:4] point_x, [35:20] point_y, [51:36] query_x
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [STATUS_BITS-1:0]   rsp_tuser,   // [1:0] range_status
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [15:0] interp_value
   input  logic                     csr_wr_en,
   input  logic [COUNT_BITS-1:0]    csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   pwl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pwl_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .point_index  (req_tdata[3:0]),
      .point_x      (req_tdata[19:4]),
      .point_y      (req_tdata[35:20]),
      .query_x      (req_tdata[51:36]),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .interp_value (rsp_tdata),
      .range_status (rsp_tuser)
   );

endmodule
